FILE: src/qxm_pkg.sv
// Package for the quad X-frame motor mixer: item structs, register indexes,
// drive mode codes and datapath widths. No dependencies.
package qxm_pkg;

  typedef struct packed {
    logic               enable_cmd;
    logic signed [31:0] thrust_cmd;
    logic signed [31:0] torque_roll;
    logic signed [31:0] torque_pitch;
    logic signed [31:0] torque_yaw;
    logic        [31:0] now_tick;
  } cmd_t;

  typedef struct packed {
    logic [15:0] motor_one;
    logic [15:0] motor_two;
    logic [15:0] motor_three;
    logic [15:0] motor_four;
    logic [1:0]  drive_mode;
  } mix_t;

  localparam logic [2:0] REG_MASS_GAIN       = 3'd0;
  localparam logic [2:0] REG_ROLL_PITCH_GAIN = 3'd1;
  localparam logic [2:0] REG_YAW_GAIN        = 3'd2;
  localparam logic [2:0] REG_CURVE_A         = 3'd3;
  localparam logic [2:0] REG_CURVE_B         = 3'd4;
  localparam logic [2:0] REG_SHUTOFF_FORCE   = 3'd5;
  localparam logic [2:0] REG_SPINUP_TICKS    = 3'd6;

  localparam logic [1:0] MODE_STOP  = 2'd0;
  localparam logic [1:0] MODE_SPIN  = 2'd1;
  localparam logic [1:0] MODE_RUN   = 2'd2;

  // Serial multiplier: 48-bit multiplicand, 32-bit multiplier, 4-bit digits
  localparam int MUL_A_W  = 48;
  localparam int MUL_B_W  = 32;
  localparam int MUL_P_W  = 80;
  localparam int DIGIT_W  = 4;
  localparam int DIGITS   = MUL_B_W / DIGIT_W;

  // Width of the root search compare
  localparam int CMP_W    = 80;

endpackage

FILE: src/qxm_mul.sv
// Digit-serial unsigned multiplier, one 4-bit digit of the multiplier per cycle.
// Depends on qxm_pkg.
module qxm_mul (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [qxm_pkg::MUL_A_W-1:0] mcand,
  input  logic [qxm_pkg::MUL_B_W-1:0] mplier,
  output logic                        done,
  output logic [qxm_pkg::MUL_P_W-1:0] prod
);
  import qxm_pkg::*;

  localparam int CNT_W = $clog2(DIGITS);

  logic [MUL_P_W-1:0]           acc;
  logic [MUL_B_W-1:0]           digits;
  logic [CNT_W-1:0]             cnt;
  logic                         busy;
  logic [MUL_A_W+DIGIT_W-1:0]   pp;

  assign pp   = {{DIGIT_W{1'b0}}, mcand} *
                {{MUL_A_W{1'b0}}, digits[MUL_B_W-1 -: DIGIT_W]};
  assign prod = acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy   <= 1'b1;
        acc    <= '0;
        digits <= mplier;
        cnt    <= CNT_W'(DIGITS - 1);
      end else if (busy) begin
        // most significant digit first: shift and add
        acc    <= {acc[MUL_P_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}} + MUL_P_W'(pp);
        digits <= {digits[MUL_B_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
        cnt    <= cnt - CNT_W'(1);
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

FILE: src/qxm_root.sv
// Bit-serial inverse of the thrust curve a*r^2 + b*FULL*r <= rhs, one ratio
// bit per compare phase, running sums kept by shift and add. Depends on qxm_pkg.
module qxm_root #(
  parameter int RATIO_WIDTH = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [31:0]               curve_a,
  input  logic [31:0]               curve_b,
  input  logic [qxm_pkg::CMP_W-1:0] rhs,
  output logic                      done,
  output logic [RATIO_WIDTH-1:0]    ratio
);
  import qxm_pkg::*;

  localparam int KW   = $clog2(RATIO_WIDTH);
  localparam int AW   = 32 + RATIO_WIDTH;
  localparam int INCW = AW + 2;

  logic [RATIO_WIDTH-1:0] r;
  logic [AW-1:0]          ar;
  logic [CMP_W-1:0]       lsum;
  logic [INCW-1:0]        inc;
  logic [KW-1:0]          k;
  logic                   busy;
  logic                   phase;

  logic [AW-1:0]    a_sh;
  logic [AW-1:0]    bf;
  logic [INCW-1:0]  inc_next;
  logic [CMP_W-1:0] cand;

  assign a_sh     = AW'(curve_a) << k;
  assign bf       = {curve_b, {RATIO_WIDTH{1'b0}}} - AW'(curve_b);
  assign inc_next = {1'b0, ar, 1'b0} + INCW'(a_sh) + INCW'(bf);
  assign cand     = lsum + (CMP_W'(inc) << k);
  assign ratio    = r;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      phase <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        phase <= 1'b0;
        r     <= '0;
        ar    <= '0;
        lsum  <= '0;
        k     <= KW'(RATIO_WIDTH - 1);
      end else if (busy) begin
        phase <= ~phase;
        if (!phase) begin
          inc <= inc_next;
        end else begin
          if (cand <= rhs) begin
            lsum <= cand;
            r[k] <= 1'b1;
            ar   <= ar + a_sh;
          end
          if (k == '0) begin
            busy <= 1'b0;
            done <= 1'b1;
          end else begin
            k <= k - KW'(1);
          end
        end
      end
    end
  end

endmodule

FILE: src/quad_x_motor_mixer.sv
// Quad X-frame motor mixer, top level: command and mix channels, register
// file and sequencer. Depends on qxm_pkg, qxm_mul and qxm_root.
//
// Each command item yields one mix item. A disabled command, or one whose
// thrust times mass_gain falls below shutoff_force, stops all motors
// (drive_mode 0), clears the running flag and stamps now_tick. While not
// running and fewer than spinup_ticks ticks have passed since that stamp,
// every motor gets the fixed spin-up ratio (drive_mode 1). Otherwise the
// thrust and torques are mixed into four motor forces, the quadratic thrust
// curve is inverted per motor and the ratio is clamped to [FULL/10, FULL]
// with FULL = 2^RATIO_WIDTH-1 (drive_mode 2). Every pass through the shared
// 4-bit-digit multiplier goes through a start, 8 digits and a pick-up. A stop
// or spin-up item passes through the accept, one multiply for the shutoff
// test, the decision and the output load. A running item adds three more
// multiplies for the torques, the mix, and per motor one multiply for the
// force scaling plus a bit-serial root search. A motor with a negative force
// skips its multiply and search and takes the floor ratio. One item is
// worked on at a time; a new command is taken as soon as the previous result
// sits in the output register, so a stalled receiver holds the input off.
module quad_x_motor_mixer #(
  parameter int RATIO_WIDTH = 16
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           cfg_we,
  input  logic [2:0]     cfg_index,
  input  logic [31:0]    cfg_data,
  input  logic           cmd_valid,
  output logic           cmd_ready,
  input  qxm_pkg::cmd_t  cmd,
  output logic           mix_valid,
  input  logic           mix_ready,
  output qxm_pkg::mix_t  mix
);
  import qxm_pkg::*;

  localparam logic [RATIO_WIDTH-1:0] FULL_RATIO  = {RATIO_WIDTH{1'b1}};
  localparam logic [RATIO_WIDTH-1:0] FLOOR_RATIO = FULL_RATIO / 10;
  localparam logic [15:0] SPIN_RATIO = 16'(10000 >> (16 - RATIO_WIDTH));
  localparam logic [31:0] FULL_SQ    = 32'(FULL_RATIO * FULL_RATIO);

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_MUL    = 9'b000000010,
    S_MWAIT  = 9'b000000100,
    S_DECIDE = 9'b000001000,
    S_MIX    = 9'b000010000,
    S_FSEL   = 9'b000100000,
    S_RSTART = 9'b001000000,
    S_RWAIT  = 9'b010000000,
    S_OUT    = 9'b100000000
  } state_t;

  typedef enum logic [2:0] {
    ST_T = 3'd0,
    ST_R = 3'd1,
    ST_P = 3'd2,
    ST_Y = 3'd3,
    ST_K = 3'd4
  } step_t;

  // configuration registers
  logic [31:0] mass_gain, roll_pitch_gain, yaw_gain, curve_a, curve_b;
  logic [30:0] shutoff_force;
  logic [15:0] spinup_ticks;

  // block state
  logic        running;
  logic [31:0] stop_stamp;

  // sequencer and datapath registers
  state_t                 state;
  step_t                  step;
  logic [1:0]             motor;
  cmd_t                   item;
  logic signed [63:0]     tprod;
  logic signed [27:0]     rterm, pterm, yterm;
  logic signed [39:0]     motor_force [4];
  logic [RATIO_WIDTH-1:0] ratio [4];
  logic [CMP_W-1:0]       rhs;
  mix_t                   res;

  // multiplier and root unit hookup
  logic               mul_start, mul_done, root_start, root_done;
  logic [MUL_A_W-1:0] mcand;
  logic [MUL_B_W-1:0] mplier;
  logic [MUL_P_W-1:0] prod;
  logic               neg;
  logic [63:0]        mag64;
  logic signed [63:0] sprod;
  logic [RATIO_WIDTH-1:0] root_ratio;
  logic signed [41:0] te, re, pe, ye;
  logic signed [41:0] fsum [4];
  logic               stop_now, spin_now;
  logic [31:0]        since_stop;

  function automatic logic [31:0] mag32(input logic signed [31:0] x);
    mag32 = x[31] ? (~x + 32'd1) : x;
  endfunction

  assign cmd_ready  = (state == S_IDLE);
  assign mul_start  = (state == S_MUL);
  assign root_start = (state == S_RSTART);

  // pick the operands of the shared multiplier by step
  always_comb begin
    mcand  = '0;
    mplier = '0;
    neg    = 1'b0;
    case (step)
      ST_T: begin
        mcand  = MUL_A_W'(mag32(item.thrust_cmd));
        mplier = mass_gain;
        neg    = item.thrust_cmd[31];
      end
      ST_R: begin
        mcand  = MUL_A_W'(mag32(item.torque_roll));
        mplier = roll_pitch_gain;
        neg    = item.torque_roll[31];
      end
      ST_P: begin
        mcand  = MUL_A_W'(mag32(item.torque_pitch));
        mplier = roll_pitch_gain;
        neg    = item.torque_pitch[31];
      end
      ST_Y: begin
        mcand  = MUL_A_W'(mag32(item.torque_yaw));
        mplier = yaw_gain;
        neg    = item.torque_yaw[31];
      end
      ST_K: begin
        mcand  = MUL_A_W'(motor_force[motor]);
        mplier = FULL_SQ;
      end
      default: begin
        mcand  = '0;
        mplier = '0;
      end
    endcase
  end

  // products stay below 2^63, so the low word plus sign gives the signed value
  assign mag64 = prod[63:0];
  assign sprod = neg ? $signed(~mag64 + 64'd1) : $signed(mag64);

  // stop and spin-up decisions from the registered thrust product
  assign stop_now   = !item.enable_cmd ||
                      (tprod < $signed({9'b0, shutoff_force, 24'b0}));
  assign since_stop = item.now_tick - stop_stamp;
  assign spin_now   = !running && (since_stop < {16'b0, spinup_ticks});

  // X-frame mix, each sum exact, then floor divide by four
  assign te = 42'(40'(tprod >>> 24));
  assign re = 42'(rterm);
  assign pe = 42'(pterm);
  assign ye = 42'(yterm);
  assign fsum[0] = (te - re - pe - ye) >>> 2;
  assign fsum[1] = (te - re + pe + ye) >>> 2;
  assign fsum[2] = (te + re + pe - ye) >>> 2;
  assign fsum[3] = (te + re - pe + ye) >>> 2;

  qxm_mul u_mul (
    .clk    (clk),
    .rst    (rst),
    .start  (mul_start),
    .mcand  (mcand),
    .mplier (mplier),
    .done   (mul_done),
    .prod   (prod)
  );

  qxm_root #(.RATIO_WIDTH(RATIO_WIDTH)) u_root (
    .clk     (clk),
    .rst     (rst),
    .start   (root_start),
    .curve_a (curve_a),
    .curve_b (curve_b),
    .rhs     (rhs),
    .done    (root_done),
    .ratio   (root_ratio)
  );

  // configuration writes; indexes past the list drop
  always_ff @(posedge clk) begin
    if (rst) begin
      mass_gain       <= 32'd452985;
      roll_pitch_gain <= 32'd515396075;
      yaw_gain        <= 32'd2818572288;
      curve_a         <= 32'd1543503;
      curve_b         <= 32'd671089;
      shutoff_force   <= 31'd293;
      spinup_ticks    <= 16'd200;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MASS_GAIN:       mass_gain       <= cfg_data;
        REG_ROLL_PITCH_GAIN: roll_pitch_gain <= cfg_data;
        REG_YAW_GAIN:        yaw_gain        <= cfg_data;
        REG_CURVE_A:         curve_a         <= cfg_data;
        REG_CURVE_B:         curve_b         <= cfg_data;
        REG_SHUTOFF_FORCE:   shutoff_force   <= cfg_data[30:0];
        REG_SPINUP_TICKS:    spinup_ticks    <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      step       <= ST_T;
      motor      <= 2'd0;
      running    <= 1'b0;
      stop_stamp <= 32'd0;
      mix_valid  <= 1'b0;
    end else begin
      // drop the valid once taken; S_OUT reloads it on its own
      if (mix_valid && mix_ready && state != S_OUT) mix_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            item  <= cmd;
            step  <= ST_T;
            state <= S_MUL;
          end
        end
        S_MUL: state <= S_MWAIT;
        S_MWAIT: begin
          if (mul_done) begin
            case (step)
              ST_T: begin
                tprod <= sprod;
                state <= S_DECIDE;
              end
              ST_R: begin
                rterm <= 28'(sprod >>> 36);
                step  <= ST_P;
                state <= S_MUL;
              end
              ST_P: begin
                pterm <= 28'(sprod >>> 36);
                step  <= ST_Y;
                state <= S_MUL;
              end
              ST_Y: begin
                yterm <= 28'(sprod >>> 36);
                state <= S_MIX;
              end
              default: begin
                // scale the force side by FULL^2 * 2^8
                rhs   <= {prod[CMP_W-9:0], 8'b0};
                state <= S_RSTART;
              end
            endcase
          end
        end
        S_DECIDE: begin
          if (stop_now) begin
            stop_stamp <= item.now_tick;
            running    <= 1'b0;
            res        <= '{16'd0, 16'd0, 16'd0, 16'd0, MODE_STOP};
            state      <= S_OUT;
          end else if (spin_now) begin
            res   <= '{SPIN_RATIO, SPIN_RATIO, SPIN_RATIO, SPIN_RATIO, MODE_SPIN};
            state <= S_OUT;
          end else begin
            running <= 1'b1;
            step    <= ST_R;
            state   <= S_MUL;
          end
        end
        S_MIX: begin
          for (int i = 0; i < 4; i++) motor_force[i] <= 40'(fsum[i]);
          motor <= 2'd0;
          step  <= ST_K;
          state <= S_FSEL;
        end
        S_FSEL: begin
          // negative force: skip the search, take the floor ratio
          if (motor_force[motor][39]) begin
            ratio[motor] <= FLOOR_RATIO;
            motor        <= motor + 2'd1;
            if (motor == 2'd3) state <= S_OUT;
          end else begin
            state <= S_MUL;
          end
        end
        S_RSTART: state <= S_RWAIT;
        S_RWAIT: begin
          if (root_done) begin
            ratio[motor] <= (root_ratio < FLOOR_RATIO) ? FLOOR_RATIO : root_ratio;
            motor        <= motor + 2'd1;
            state        <= (motor == 2'd3) ? S_OUT : S_FSEL;
          end
        end
        S_OUT: begin
          // hold until the output register is free
          if (!mix_valid || mix_ready) begin
            if (step == ST_K) begin
              mix <= '{16'(ratio[0]), 16'(ratio[1]), 16'(ratio[2]), 16'(ratio[3]),
                       MODE_RUN};
            end else begin
              mix <= res;
            end
            mix_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: src/qxm_checker.sv
// Port-level checks on the mix channel of the motor mixer, bound to the top.
// Depends on qxm_pkg and quad_x_motor_mixer.
module qxm_checker (
  input logic          clk,
  input logic          rst,
  input logic          mix_valid,
  input logic          mix_ready,
  input qxm_pkg::mix_t mix
);
  import qxm_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    mix_valid && !mix_ready |=> mix_valid && $stable(mix))
    else $error("mix item dropped or changed while stalled");

  a_mode: assert property (@(posedge clk) disable iff (rst)
    mix_valid |-> (mix.drive_mode == MODE_STOP || mix.drive_mode == MODE_SPIN ||
                   mix.drive_mode == MODE_RUN))
    else $error("bad drive mode");

  a_stop: assert property (@(posedge clk) disable iff (rst)
    mix_valid && mix.drive_mode == MODE_STOP |->
      mix.motor_one == 16'd0 && mix.motor_two == 16'd0 &&
      mix.motor_three == 16'd0 && mix.motor_four == 16'd0)
    else $error("stopped item with nonzero motor");

  a_run: assert property (@(posedge clk) disable iff (rst)
    mix_valid && mix.drive_mode == MODE_RUN |->
      mix.motor_one != 16'd0 && mix.motor_two != 16'd0 &&
      mix.motor_three != 16'd0 && mix.motor_four != 16'd0)
    else $error("running item below floor ratio");

  a_spin: assert property (@(posedge clk) disable iff (rst)
    mix_valid && mix.drive_mode == MODE_SPIN |->
      mix.motor_one == mix.motor_two && mix.motor_two == mix.motor_three &&
      mix.motor_three == mix.motor_four && mix.motor_one != 16'd0)
    else $error("spin-up motors differ");

endmodule

bind quad_x_motor_mixer qxm_checker u_qxm_checker (
  .clk       (clk),
  .rst       (rst),
  .mix_valid (mix_valid),
  .mix_ready (mix_ready),
  .mix       (mix)
);
